[src/sirt_pkg.sv]
// sirt_pkg: shared types, constants and helper functions for the radix text converter
// no dependencies; used by sirt_alpha_check and signed_integer_to_radix_text
`default_nettype none

package sirt_pkg;

    localparam int ALPHA_BYTES = 16;
    localparam int MAX_BASE_DEF = 16;
    localparam int BASE_W = 5;
    localparam int DIG_W = 4;
    localparam int DIG_DEPTH = 32;
    localparam int DIG_IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int VALUE_W = 32;
    localparam int CFG_W = 64;

    localparam logic [7:0] MINUS_SIGN = 8'h2D;
    localparam logic [7:0] PLUS_SIGN = 8'h2B;

    localparam logic [CFG_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] ALPHA_HI_RST = 64'h0000000000003938;

    typedef enum logic {
        REG_ALPHA_LO = 1'b0,
        REG_ALPHA_HI = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] base;
    } t_alpha_info;

    // symbol byte at a digit position, symbol 0 in the lowest byte of the low word
    function automatic logic [7:0] symbol_at(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [DIG_W-1:0] idx
    );
        logic [2*CFG_W-1:0] all;
        all = {hi, lo};
        return all[{idx, 3'b000} +: 8];
    endfunction

    // floor(2^32 / base); quotient estimate from it is low by at most one
    function automatic logic [VALUE_W-1:0] recip(input logic [BASE_W-1:0] base);
        logic [VALUE_W-1:0] r;
        case (base)
            5'd2:    r = 32'd2147483648;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741824;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870912;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd14:   r = 32'd306783378;
            5'd15:   r = 32'd286331153;
            5'd16:   r = 32'd268435456;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/sirt_alpha_check.sv]
// sirt_alpha_check: derives the base and validity of the configured digit alphabet
// depends on sirt_pkg
`default_nettype none

module sirt_alpha_check #(
    parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
    input  wire logic [sirt_pkg::CFG_W-1:0] i_alpha_lo,
    input  wire logic [sirt_pkg::CFG_W-1:0] i_alpha_hi,
    output sirt_pkg::t_alpha_info            o_info
);

    localparam int NB = sirt_pkg::ALPHA_BYTES;

    logic [7:0]    w_sym [NB];
    logic [NB-1:0] w_in;
    logic          w_bad;

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            w_sym[i] = sirt_pkg::symbol_at(i_alpha_lo, i_alpha_hi, sirt_pkg::DIG_W'(i));
        end
        // a position is in the alphabet if no zero byte came at or before it and its index is below MAX_BASE
        w_in[0] = (w_sym[0] != 8'd0) && (MAX_BASE > 0);
        for (int i = 1; i < NB; i++) begin
            w_in[i] = w_in[i-1] && (w_sym[i] != 8'd0) && (i < MAX_BASE);
        end
    end

    always_comb begin
        w_bad = 1'b0;
        for (int i = 0; i < NB; i++) begin
            if (w_in[i] && ((w_sym[i] == sirt_pkg::MINUS_SIGN) ||
                            (w_sym[i] == sirt_pkg::PLUS_SIGN))) begin
                w_bad = 1'b1;
            end
            for (int j = i + 1; j < NB; j++) begin
                if (w_in[j] && (w_sym[i] == w_sym[j])) begin
                    w_bad = 1'b1;
                end
            end
        end
    end

    assign o_info.base  = sirt_pkg::BASE_W'($countones(w_in));
    assign o_info.valid = !w_bad && ($countones(w_in) >= 2);

endmodule

`default_nettype wire

[src/signed_integer_to_radix_text.sv]
// signed_integer_to_radix_text: top level, signed 32-bit number to text in a configured base
// depends on sirt_pkg and sirt_alpha_check
//
// A request is taken on start while busy is low. The number is split into digits
// by one shared reciprocal-multiply divider: each digit passes through S_MUL (a
// 32x32 multiply), then S_FIX (a small multiply, subtract and single correction).
// The text then leaves one character per cycle on o_character with o_strobe, '-'
// first for a negative number, o_last on the final digit. The receiver cannot
// stall, so the strobe is never held. The next request can be taken at the edge
// that ends the final character. An invalid alphabet (under two symbols, a repeat,
// or a '+' or '-') gives no characters and the request finishes at once. The
// alphabet registers may only be written while busy is low.
`default_nettype none

module signed_integer_to_radix_text #(
    parameter int MAX_BASE = sirt_pkg::MAX_BASE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [31:0]           i_value,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [sirt_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                              o_strobe,
    output logic [7:0]                        o_character,
    output logic                              o_last
);

    localparam int VW = sirt_pkg::VALUE_W;
    localparam int BW = sirt_pkg::BASE_W;
    localparam int DW = sirt_pkg::DIG_W;
    localparam int IW = sirt_pkg::DIG_IDX_W;
    localparam int CW = sirt_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_SIGN,
        S_EMIT
    } t_state;

    // configuration registers
    logic [sirt_pkg::CFG_W-1:0] r_alpha_lo;
    logic [sirt_pkg::CFG_W-1:0] r_alpha_hi;

    // sequencer and datapath
    t_state          r_state;
    logic [VW-1:0]   r_mag;
    logic [VW-1:0]   r_recip;
    logic [2*VW-1:0] r_prod;
    logic [BW-1:0]   r_base;
    logic            r_neg;
    logic [CW-1:0]   r_cnt;
    logic [IW-1:0]   r_emit_idx;
    logic [DW-1:0]   r_digits [sirt_pkg::DIG_DEPTH];

    sirt_pkg::t_alpha_info w_info;

    logic            w_take;
    logic [VW-1:0]   w_in_mag;
    logic [2*VW-1:0] w_prod;
    logic [VW-1:0]   w_q0;
    logic [VW-1:0]   w_qb;
    logic [VW-1:0]   w_rem;
    logic [CW-1:0]   w_rem6;
    logic            w_ge;
    logic [DW-1:0]   w_digit;
    logic [VW-1:0]   w_q;
    logic            w_done;

    sirt_alpha_check #(
        .MAX_BASE (MAX_BASE)
    ) u_alpha (
        .i_alpha_lo (r_alpha_lo),
        .i_alpha_hi (r_alpha_hi),
        .o_info     (w_info)
    );

    // config writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo <= sirt_pkg::ALPHA_LO_RST;
            r_alpha_hi <= sirt_pkg::ALPHA_HI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sirt_pkg::REG_ALPHA_LO: r_alpha_lo <= i_cfg_wdata;
                sirt_pkg::REG_ALPHA_HI: r_alpha_hi <= i_cfg_wdata;
                default:                r_alpha_lo <= r_alpha_lo;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_take   = start && !busy;

    // magnitude of the request, most negative number maps to 2^31
    assign w_in_mag = i_value[VW-1] ? (~i_value + 32'd1) : i_value;

    // step one: quotient estimate from the reciprocal
    assign w_prod   = r_mag * r_recip;

    // step two: remainder, one correction since the estimate is low by at most one
    assign w_q0     = r_prod[2*VW-1:VW];
    assign w_qb     = w_q0 * {{(VW-BW){1'b0}}, r_base};
    assign w_rem    = r_mag - w_qb;
    assign w_rem6   = w_rem[CW-1:0];
    assign w_ge     = (w_rem6 >= {{(CW-BW){1'b0}}, r_base});
    assign w_digit  = w_ge ? DW'(w_rem6 - {{(CW-BW){1'b0}}, r_base}) : w_rem6[DW-1:0];
    assign w_q      = w_q0 + {{(VW-1){1'b0}}, w_ge};
    assign w_done   = (w_q == '0) || (r_cnt == CW'(sirt_pkg::DIG_DEPTH - 1));

    // digit store, indexes into the alphabet
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIX) begin
            r_digits[r_cnt[IW-1:0]] <= w_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_emit_idx  <= '0;
            o_strobe    <= 1'b0;
            o_last      <= 1'b0;
            o_character <= 8'd0;
        end else begin
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // invalid alphabet: request taken, nothing emitted
                    if (w_take && w_info.valid) begin
                        r_mag   <= w_in_mag;
                        r_neg   <= i_value[VW-1];
                        r_base  <= w_info.base;
                        r_recip <= sirt_pkg::recip(w_info.base);
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_mag <= w_q;
                    r_cnt <= r_cnt + CW'(1);
                    if (w_done) begin
                        r_emit_idx <= r_cnt[IW-1:0];
                        r_state    <= r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SIGN: begin
                    o_strobe    <= 1'b1;
                    o_character <= sirt_pkg::MINUS_SIGN;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    // most significant digit first
                    o_strobe    <= 1'b1;
                    o_character <= sirt_pkg::symbol_at(r_alpha_lo, r_alpha_hi,
                                                       r_digits[r_emit_idx]);
                    if (r_emit_idx == '0) begin
                        o_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_emit_idx <= r_emit_idx - IW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // reciprocal estimate leaves the remainder below twice the base
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> (w_rem < {{(VW-BW-1){1'b0}}, r_base, 1'b0}))
        else $error("remainder out of range after reciprocal estimate");

    // corrected digit is always a valid alphabet index
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> ({1'b0, w_digit} < r_base))
        else $error("digit not below base");

    // digit count never passes the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(sirt_pkg::DIG_DEPTH))
        else $error("digit count overflow");

    // the final character ends the request
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (r_state == S_IDLE))
        else $error("last character while still busy");

    // a sign is always followed by at least one digit
    a_sign_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_character == sirt_pkg::MINUS_SIGN) && $past(r_state == S_SIGN))
        |-> (r_state == S_EMIT) ##1 o_strobe)
        else $error("sign without digits");

endmodule

`default_nettype wire

[verif/tb_signed_integer_to_radix_text.sv]
// tb_signed_integer_to_radix_text: self-checking bench for the signed integer to radix text block
// depends on sirt_pkg and signed_integer_to_radix_text; predicts every character and compares

module tb_signed_integer_to_radix_text;
    timeunit 1ns;
    timeprecision 1ps;

    // slowest request is the most negative number in base two
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // dut ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [31:0]         i_value = '0;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_idx = sirt_pkg::REG_ALPHA_LO;
    logic [sirt_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                       o_strobe;
    logic [7:0]                 o_character;
    logic                       o_last;

    // shadow of the alphabet registers, starts at reset contents
    logic [sirt_pkg::CFG_W-1:0] alpha_lo = sirt_pkg::ALPHA_LO_RST;
    logic [sirt_pkg::CFG_W-1:0] alpha_hi = sirt_pkg::ALPHA_HI_RST;

    logic [31:0] pending_values[$];
    t_text_char  expected_text[$];

    // sender burst control
    int burst_left = 0;
    int gap_left = 0;

    int errors = 0;
    int requests_taken = 0;
    int chars_checked = 0;
    int silent_requests = 0;
    int alphabets_used = 1;
    int cycle_count = 0;

    signed_integer_to_radix_text i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // number of symbols for the current alphabet, zero when the alphabet is unusable
    function automatic int alphabet_radix();
        logic [127:0] bytes;
        int len;
        bytes = {alpha_hi, alpha_lo};
        len = 0;
        while (len < 16 && bytes[8*len +: 8] != 8'h00)
            len++;
        if (len < 2)
            return 0;
        for (int i = 0; i < len; i++) begin
            if (bytes[8*i +: 8] == sirt_pkg::MINUS_SIGN ||
                bytes[8*i +: 8] == sirt_pkg::PLUS_SIGN)
                return 0;
            for (int j = i + 1; j < len; j++)
                if (bytes[8*j +: 8] == bytes[8*i +: 8])
                    return 0;
        end
        return len;
    endfunction

    // queue the characters one request should produce
    task automatic predict_text(input logic [31:0] number);
        logic [127:0] bytes;
        logic [7:0]   digit_chars[32];
        logic [31:0]  mag;
        int           radix;
        int           ndig;
        bytes = {alpha_hi, alpha_lo};
        radix = alphabet_radix();
        if (radix == 0) begin
            silent_requests++;
            return;
        end
        // two's complement negate also covers the most negative number as unsigned
        mag = number[31] ? (~number + 32'd1) : number;
        ndig = 0;
        do begin
            digit_chars[ndig] = bytes[8*(mag % radix) +: 8];
            mag = mag / radix;
            ndig++;
        end while (mag != 0 && ndig < 32);
        if (number[31])
            expected_text.push_back('{ch: sirt_pkg::MINUS_SIGN, last: 1'b0});
        for (int k = ndig - 1; k >= 0; k--)
            expected_text.push_back('{ch: digit_chars[k], last: (k == 0)});
    endtask

    // sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        logic        nxt_start;
        logic [31:0] nxt_value;
        nxt_start = start;
        nxt_value = i_value;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && !busy) begin
                // request taken at this edge
                predict_text(i_value);
                requests_taken++;
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_values.size() > 0) begin
                    nxt_start = 1'b1;
                    nxt_value = pending_values.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // close the burst: mostly short gaps, sometimes long enough
                        // to land on any phase of the conversion
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                                 : $urandom_range(0, 6);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 110)
                                                               : $urandom_range(0, 3);
                    end
                end
            end
        end
        start <= nxt_start;
        i_value <= nxt_value;
    end

    // result checker: receiver cannot stall, every strobe is taken
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          o_character, o_last));
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (o_character !== want.ch)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              o_character, want.ch));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                              o_last, want.last, want.ch));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("signed_integer_to_radix_text verification failed");
            $finish;
        end
    end

    // wait until every request is out and the block has gone quiet
    task automatic drain();
        do
            @(posedge i_clk);
        while (pending_values.size() != 0 || start || busy || expected_text.size() != 0);
        // unusable alphabets give no characters, so give the block time to finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // idle the block, then load both alphabet words
    task automatic apply_alphabet(input logic [sirt_pkg::CFG_W-1:0] lo,
                                  input logic [sirt_pkg::CFG_W-1:0] hi);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= sirt_pkg::REG_ALPHA_LO;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_idx <= sirt_pkg::REG_ALPHA_HI;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        alpha_lo = lo;
        alpha_hi = hi;
        alphabets_used++;
    endtask

    // random alphabet of len distinct symbols, optionally spoiled by a repeat or a sign
    task automatic random_alphabet(input int len, input bit spoil,
                                   output logic [sirt_pkg::CFG_W-1:0] lo,
                                   output logic [sirt_pkg::CFG_W-1:0] hi);
        logic [127:0] bytes;
        bit           taken[256];
        logic [7:0]   c;
        int           a;
        int           b;
        bytes = '0;
        for (int i = 0; i < len; i++) begin
            do
                c = 8'($urandom_range(1, 255));
            while (taken[c] || c == sirt_pkg::MINUS_SIGN || c == sirt_pkg::PLUS_SIGN);
            taken[c] = 1'b1;
            bytes[8*i +: 8] = c;
        end
        if (spoil) begin
            a = int'($urandom_range(0, len - 1));
            case ($urandom_range(0, 2))
                0: begin
                    do
                        b = int'($urandom_range(0, len - 1));
                    while (b == a);
                    bytes[8*b +: 8] = bytes[8*a +: 8];
                end
                1: bytes[8*a +: 8] = sirt_pkg::MINUS_SIGN;
                default: bytes[8*a +: 8] = sirt_pkg::PLUS_SIGN;
            endcase
        end
        // junk behind the terminator must be ignored
        for (int i = len + 1; i < 16; i++)
            bytes[8*i +: 8] = 8'($urandom);
        lo = bytes[63:0];
        hi = bytes[127:64];
    endtask

    function automatic logic [31:0] random_number();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3: return 32'($signed($urandom_range(0, 400)) - 200);
            4: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h8000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [sirt_pkg::CFG_W-1:0] lo;
        logic [sirt_pkg::CFG_W-1:0] hi;
        int                         len;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset alphabet, decimal: zero, single digits and ten of both signs, extremes
        pending_values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};

        // base two, the longest text including 33 characters for the most negative number
        apply_alphabet(64'h3130, 64'h0);
        pending_values = '{32'd0, -32'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555};

        // sixteen symbols with no terminator at all
        apply_alphabet(64'h3736353433323130, 64'h6665646362613938);
        pending_values = '{-32'sd15, 32'd16, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        // repeat after the terminator does not count: still base two
        apply_alphabet(64'h3130_0000_3130, 64'h3130);
        pending_values = '{-32'sd2};

        // unusable alphabets: empty, one symbol, a repeat, a minus, a plus
        apply_alphabet(64'h0, 64'hDEAD_BEEF);
        pending_values = '{32'd5};
        apply_alphabet(64'h41, 64'h4242);
        pending_values = '{-32'sd1};
        apply_alphabet(64'h3031_3130, 64'h0);
        pending_values = '{32'd7};
        apply_alphabet(64'h2D_3130, 64'h0);
        pending_values = '{-32'sd7};
        apply_alphabet(64'h3736353433323130, 64'h2B_3938);
        pending_values = '{32'h8000_0000};

        // random alphabets, extremes of the size first
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                len = 2;
            else if (phase == 1)
                len = 16;
            else
                len = $urandom_range(2, 16);
            random_alphabet(len, (phase > 1) && ($urandom_range(0, 4) == 0), lo, hi);
            apply_alphabet(lo, hi);
            for (int n = 0; n < 12; n++)
                pending_values.push_back(random_number());
        end

        // everything must arrive, then a quiet spell to catch stray characters
        drain();

        $display("%0d requests over %0d alphabets, %0d characters checked, %0d silent",
                 requests_taken, alphabets_used, chars_checked, silent_requests);
        if (errors == 0) begin
            $display("signed_integer_to_radix_text verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("signed_integer_to_radix_text verification failed");
        end
        $finish;
    end

endmodule
